// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the timestamp FIFO modules.
// No dependencies; the files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define TWM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked on every clock edge, during reset too.
`define TWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define TWM_ASSERT(lbl, clk, rstn, prop, msg)
`define TWM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/twm_pkg.sv =====
// Shared constants, types and helpers of the timestamp FIFO.
// No dependencies; imported by every module of the block.
package twm_pkg;

  localparam int DEPTH    = 128;
  localparam int TAG_BITS = 32;

  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int TIME_W    = 47;
  localparam int OFF_W     = 48;
  localparam int WIN_W     = 24;
  localparam int LT_W      = TIME_W + 2;
  localparam int PAYLOAD_W = 32;
  localparam int OCC_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(100000);

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_DROP  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef struct packed {
    logic capture;
    logic push;
    logic clear;
    logic pop;
    logic match;
    logic finish;
  } twm_cmd_t;

  typedef struct packed {
    logic  sync;
    kind_e kind;
    logic  empty;
    logic  below_lo;
    logic  below_hi;
    logic  at_or_before;
  } twm_stat_t;

  function automatic logic [PTR_W-1:0] twm_next(input logic [PTR_W-1:0] idx);
    if (idx == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return idx + PTR_W'(1);
  endfunction

endpackage

// ===== rtl/twm_dpath.sv =====
// Datapath of the timestamp FIFO: registers, entry memory, pointers and compares.
// Depends on twm_pkg and assert_macros.svh; driven by twm_ctrl commands.
`include "assert_macros.svh"

module twm_dpath import twm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  twm_cmd_t             cmd_i,
  output twm_stat_t            stat_o,
  input  logic [1:0]           kind_i,
  input  logic [TIME_W-1:0]    time_us_i,
  input  logic [PAYLOAD_W-1:0] payload_tag_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 found_o,
  output logic [PAYLOAD_W-1:0] payload_out_o,
  output logic                 dropped_oldest_o,
  output logic                 ignored_o,
  output logic [OCC_W-1:0]     occupancy_o
);

  logic                    sync_q;
  logic [OFF_W-1:0]        offset_q;
  logic [WIN_W-1:0]        window_q;

  kind_e                   kind_q;
  logic [TIME_W-1:0]       time_q;
  logic [TAG_BITS-1:0]     tag_q;
  logic signed [LT_W-1:0]  lo_q, hi_q;

  logic [PTR_W-1:0]        head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    full;

  logic [TIME_W-1:0]       mem_time [DEPTH];
  logic [TAG_BITS-1:0]     mem_tag  [DEPTH];
  logic [TIME_W-1:0]       rd_time_q;
  logic [TAG_BITS-1:0]     rd_tag_q;

  logic signed [LT_W-1:0]  front_lt, target_lt, win_ext, time_ext;

  logic                    found_q, dropped_q, ignored_q;
  logic [PAYLOAD_W-1:0]    payload_q;
  logic [OCC_W-1:0]        occ_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q   <= 1'b0;
      offset_q <= '0;
      window_q <= WINDOW_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SYNC)   sync_q   <= cfg_data_i[0];
      if (cfg_index_i == CFG_OFFSET) offset_q <= cfg_data_i[OFF_W-1:0];
      if (cfg_index_i == CFG_WINDOW) window_q <= cfg_data_i[WIN_W-1:0];
    end
  end

  // The window bounds are worked out once, when the beat is taken.
  assign time_ext = $signed({{(LT_W - TIME_W){1'b0}}, time_us_i});
  assign win_ext  = $signed({{(LT_W - WIN_W){1'b0}}, window_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_e'(kind_i);
      time_q <= time_us_i;
      tag_q  <= TAG_BITS'(payload_tag_i);
      lo_q   <= time_ext - win_ext;
      hi_q   <= time_ext + win_ext;
    end
  end

  assign full = (count_q == CNT_W'(DEPTH));

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.clear) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (cmd_i.push) begin
      tail_d = twm_next(tail_q);
      if (full) begin
        head_d = twm_next(head_q);
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (cmd_i.pop) begin
      head_d  = twm_next(head_q);
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // The read address follows the next head, so the front entry is ready
  // in the cycle after a pop and the scan retires one entry per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_time[tail_q] <= time_q;
      mem_tag[tail_q]  <= tag_q;
    end
    rd_time_q <= mem_time[head_d];
    rd_tag_q  <= mem_tag[head_d];
  end

  assign front_lt  = $signed({{(LT_W - TIME_W){1'b0}}, rd_time_q})
                   + $signed({{(LT_W - OFF_W){offset_q[OFF_W-1]}}, offset_q});
  assign target_lt = $signed({{(LT_W - TIME_W){1'b0}}, time_q});

  assign stat_o.sync         = sync_q;
  assign stat_o.kind         = kind_q;
  assign stat_o.empty        = (count_q == '0);
  assign stat_o.below_lo     = (front_lt < lo_q);
  assign stat_o.below_hi     = (front_lt < hi_q);
  assign stat_o.at_or_before = (front_lt <= target_lt);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      found_q   <= cmd_i.match;
      payload_q <= cmd_i.match ? PAYLOAD_W'(rd_tag_q) : '0;
      dropped_q <= cmd_i.push & full;
      ignored_q <= ~sync_q;
      occ_q     <= OCC_W'(count_d);
    end
  end

  assign found_o          = found_q;
  assign payload_out_o    = payload_q;
  assign dropped_oldest_o = dropped_q;
  assign ignored_o        = ignored_q;
  assign occupancy_o      = occ_q;

  `TWM_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH), "count beyond depth")
  `TWM_ASSERT(a_pop_nonempty, clk_i, rst_ni, cmd_i.pop |-> count_q != '0, "pop on empty FIFO")
  `TWM_ASSERT(a_clear_empties, clk_i, rst_ni, cmd_i.clear |=> count_q == '0 && head_q == tail_q,
              "clear left entries")

endmodule

// ===== rtl/twm_ctrl.sv =====
// Controller of the timestamp FIFO: item sequencing and the pop scan.
// Depends on twm_pkg and assert_macros.svh; commands twm_dpath.
`include "assert_macros.svh"

module twm_ctrl import twm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  input  twm_stat_t stat_i,
  output twm_cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic done_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!stat_i.sync) begin
          cmd_o.finish = 1'b1;
        end else begin
          unique case (stat_i.kind)
            KIND_PUSH: begin
              cmd_o.push   = 1'b1;
              cmd_o.finish = 1'b1;
            end
            KIND_CLEAR: begin
              cmd_o.clear  = 1'b1;
              cmd_o.finish = 1'b1;
            end
            KIND_QUERY: begin
              // Stale entries go one a cycle; the first entry that is not stale, or an empty FIFO, ends it.
              priority if (stat_i.empty) begin
                cmd_o.finish = 1'b1;
              end else if (stat_i.below_lo) begin
                cmd_o.pop = 1'b1;
              end else if (stat_i.below_hi) begin
                cmd_o.pop    = 1'b1;
                cmd_o.match  = 1'b1;
                cmd_o.finish = 1'b1;
              end else begin
                cmd_o.finish = 1'b1;
              end
            end
            KIND_DROP: begin
              if (!stat_i.empty && stat_i.at_or_before) begin
                cmd_o.pop = 1'b1;
              end else begin
                cmd_o.finish = 1'b1;
              end
            end
            default: begin
              cmd_o.finish = 1'b1;
            end
          endcase
        end
        if (cmd_o.finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.finish;
    end
  end

  assign busy_o = (state_q == ST_RUN);
  assign done_o = done_q;

  `TWM_ASSERT(a_done_single, clk_i, rst_ni, done_q |=> !done_q, "result strobe held")
  `TWM_ASSERT(a_accept_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o,
              "accepted beat did not start work")
  `TWM_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> state_q == ST_IDLE && !done_q,
                     "controller active in reset")

endmodule

// ===== rtl/time_window_match_fifo_core.sv =====
// Top level of the timestamp-aligned FIFO: configuration, controller and datapath.
// Depends on twm_pkg, twm_ctrl and twm_dpath.
//
// Each item raised on start_i while busy_o is low is taken at that clock edge and
// produces exactly one result, shown for one cycle with done_o high; the receiver
// cannot stall, so it must capture the result in that cycle. Push, clear and any item
// with sync disabled end at once in the run state, with a registered result. A query or
// drop stays in the run state while it discards entries on the way, since the scan
// over the entry memory retires one front entry per cycle through its registered read
// port; the entry that a query returns is popped in its final cycle at no extra cost.
// busy_o falls in the cycle the result is shown, so a new item may be taken then.
// Configuration writes are always ready and should be issued only while idle.
module time_window_match_fifo_core import twm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           kind_i,
  input  logic [TIME_W-1:0]    time_us_i,
  input  logic [PAYLOAD_W-1:0] payload_tag_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 done_o,
  output logic                 found_o,
  output logic [PAYLOAD_W-1:0] payload_out_o,
  output logic                 dropped_oldest_o,
  output logic                 ignored_o,
  output logic [OCC_W-1:0]     occupancy_o
);

  twm_cmd_t  cmd;
  twm_stat_t stat;

  assign cfg_ready_o = 1'b1;

  twm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  twm_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (kind_i),
    .time_us_i       (time_us_i),
    .payload_tag_i   (payload_tag_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .found_o         (found_o),
    .payload_out_o   (payload_out_o),
    .dropped_oldest_o(dropped_oldest_o),
    .ignored_o       (ignored_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

// ===== test/twm_checker.sv =====
// Scoreboard for the timestamp-aligned FIFO: mirrors its contents and registers,
// predicts one result per accepted item and compares each strobed result.
// Depends on twm_pkg for widths, depth, item kinds and register indexes.
module twm_checker import twm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [1:0]           kind_i,
  input  logic [TIME_W-1:0]    time_us_i,
  input  logic [PAYLOAD_W-1:0] payload_tag_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 done_i,
  input  logic                 found_i,
  input  logic [PAYLOAD_W-1:0] payload_out_i,
  input  logic                 dropped_oldest_i,
  input  logic                 ignored_i,
  input  logic [OCC_W-1:0]     occupancy_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                 found;
    logic [PAYLOAD_W-1:0] payload;
    logic                 dropped;
    logic                 ignored;
    logic [OCC_W-1:0]     occupancy;
  } fifo_result_t;

  logic [TIME_W-1:0]    held_time [DEPTH];
  logic [PAYLOAD_W-1:0] held_tag  [DEPTH];
  logic [PTR_W-1:0]     rd_ptr     = '0;
  logic [PTR_W-1:0]     wr_ptr     = '0;
  int                   fill_level = 0;

  logic             sync_on   = 1'b0;
  logic [OFF_W-1:0] offset_us = '0;
  logic [WIN_W-1:0] window_us = WINDOW_RESET;

  fifo_result_t due_results[$];
  int unsigned  errors = 0;

  function automatic longint front_local_time();
    longint off;
    off = longint'($signed(offset_us));
    return longint'(held_time[rd_ptr]) + off;
  endfunction

  function automatic void retire_front();
    rd_ptr = twm_next(rd_ptr);
    fill_level--;
  endfunction

  function automatic fifo_result_t fifo_step(kind_e k, logic [TIME_W-1:0] t,
                                             logic [PAYLOAD_W-1:0] tag);
    fifo_result_t r;
    longint       target;
    longint       lo;
    longint       hi;
    r      = '0;
    target = longint'(t);
    lo     = target - longint'(window_us);
    hi     = target + longint'(window_us);
    if (!sync_on) begin
      r.ignored = 1'b1;
    end else begin
      case (k)
        KIND_PUSH: begin
          // A full FIFO loses its oldest entry to make room.
          if (fill_level == DEPTH) begin
            retire_front();
            r.dropped = 1'b1;
          end
          held_time[wr_ptr] = t;
          held_tag[wr_ptr]  = tag;
          wr_ptr = twm_next(wr_ptr);
          fill_level++;
        end
        KIND_QUERY: begin
          while (fill_level > 0 && front_local_time() < lo) begin
            retire_front();
          end
          if (fill_level > 0 && front_local_time() < hi) begin
            r.found   = 1'b1;
            r.payload = held_tag[rd_ptr];
            retire_front();
          end
        end
        KIND_DROP: begin
          while (fill_level > 0 && front_local_time() <= target) begin
            retire_front();
          end
        end
        default: begin
          rd_ptr     = '0;
          wr_ptr     = '0;
          fill_level = 0;
        end
      endcase
    end
    r.occupancy = OCC_W'(fill_level);
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fifo_result_t want;
    if (!rst_ni) begin
      rd_ptr     = '0;
      wr_ptr     = '0;
      fill_level = 0;
      sync_on    = 1'b0;
      offset_us  = '0;
      window_us  = WINDOW_RESET;
      due_results.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      // The result shown at this edge belongs to an item taken earlier, so it is
      // compared before an item accepted at the same edge is predicted.
      if (done_i) begin
        if (due_results.size() == 0) begin
          $error("result beat with no prediction outstanding");
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("found", 64'(want.found), 64'(found_i));
          check_field("payload_out", 64'(want.payload), 64'(payload_out_i));
          check_field("dropped_oldest", 64'(want.dropped), 64'(dropped_oldest_i));
          check_field("ignored", 64'(want.ignored), 64'(ignored_i));
          check_field("occupancy", 64'(want.occupancy), 64'(occupancy_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SYNC:   sync_on   = cfg_data_i[0];
          CFG_OFFSET: offset_us = cfg_data_i[OFF_W-1:0];
          CFG_WINDOW: window_us = cfg_data_i[WIN_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        due_results.push_back(fifo_step(kind_e'(kind_i), time_us_i, payload_tag_i));
      end
      pending_o    <= due_results.size();
      fail_count_o <= errors;
    end
  end

endmodule

// ===== test/time_window_match_fifo_core_tb.sv =====
// Top of the timestamp FIFO testbench: clock, reset, register writes and item stimulus.
// Depends on twm_pkg, the block time_window_match_fifo_core and the scoreboard twm_checker.
module time_window_match_fifo_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twm_pkg::*;

  localparam longint TIME_MAX = (longint'(1) << TIME_W) - 1;
  localparam longint OFF_MIN  = -(longint'(1) << (OFF_W - 1));
  localparam longint OFF_MAX  = (longint'(1) << (OFF_W - 1)) - 1;
  localparam longint WIN_MAX  = 10000000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic [1:0]           kind      = KIND_PUSH;
  logic [TIME_W-1:0]    time_us   = '0;
  logic [PAYLOAD_W-1:0] tag       = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC;
  logic [CFG_W-1:0]     cfg_data  = '0;

  logic                 busy;
  logic                 cfg_ready;
  logic                 done;
  logic                 found;
  logic [PAYLOAD_W-1:0] payload_out;
  logic                 dropped_oldest;
  logic                 ignored;
  logic [OCC_W-1:0]     occupancy;
  int unsigned          fail_count;
  int unsigned          pending;

  int burst_left = 1;
  bit no_gaps    = 1'b0;

  time_window_match_fifo_core u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_o           (busy),
    .kind_i           (kind),
    .time_us_i        (time_us),
    .payload_tag_i    (tag),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .done_o           (done),
    .found_o          (found),
    .payload_out_o    (payload_out),
    .dropped_oldest_o (dropped_oldest),
    .ignored_o        (ignored),
    .occupancy_o      (occupancy)
  );

  twm_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .kind_i           (kind),
    .time_us_i        (time_us),
    .payload_tag_i    (tag),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .done_i           (done),
    .found_i          (found),
    .payload_out_i    (payload_out),
    .dropped_oldest_i (dropped_oldest),
    .ignored_i        (ignored),
    .occupancy_i      (occupancy),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [TIME_W-1:0] clamp_time(longint v);
    if (v < 0) begin
      return '0;
    end
    if (v > TIME_MAX) begin
      return TIME_MAX[TIME_W-1:0];
    end
    return v[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] any_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  // Leaves start high on return, so the next beat can follow without a gap.
  task automatic send_item(kind_e k, logic [TIME_W-1:0] t, logic [PAYLOAD_W-1:0] tg);
    start   <= 1'b1;
    kind    <= k;
    time_us <= t;
    tag     <= tg;
    do @(posedge clk); while (busy);
  endtask

  task automatic issue(kind_e k, logic [TIME_W-1:0] t, logic [PAYLOAD_W-1:0] tg);
    int gap;
    send_item(k, t, tg);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Unused upper data bits carry noise; the block keeps only the register's width.
  task automatic set_regs(bit sync, longint off, longint win);
    logic [CFG_W-1:0] d;
    write_reg(CFG_OFFSET, off[CFG_W-1:0]);
    d = CFG_W'({$urandom, $urandom});
    d[WIN_W-1:0] = win[WIN_W-1:0];
    write_reg(CFG_WINDOW, d);
    d = CFG_W'({$urandom, $urandom});
    d[0] = sync;
    write_reg(CFG_SYNC, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int          phase_no;
    int          n_items;
    int          r;
    int          useful;
    int          sel;
    bit          sync_v;
    bit          fill;
    longint      off_v;
    longint      win_v;
    longint      sensor;
    longint      step_max;
    longint      lag;
    longint      jitter;
    logic [63:0] wide;

    phase_no = 0;
    useful   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sync is off after reset: every kind, clear included, is ignored.
    send_item(KIND_PUSH, 47'd5, 32'h1234_5678);
    send_item(KIND_QUERY, 47'd5, '0);
    send_item(KIND_DROP, TIME_MAX[TIME_W-1:0], '0);
    send_item(KIND_CLEAR, '0, '0);
    start <= 1'b0;
    drain();

    // Only sync is written here, so offset and window keep their reset values.
    write_reg(CFG_SYNC, CFG_W'(1));
    cfg_valid <= 1'b0;

    send_item(KIND_PUSH, 47'd0, 32'h0000_0000);
    send_item(KIND_PUSH, 47'd200000, 32'hFFFF_FFFF);
    send_item(KIND_PUSH, 47'd300000, 32'hA5A5_A5A5);
    send_item(KIND_QUERY, 47'd100000, '0);
    // Front entry sits exactly on the upper window edge and must not match.
    send_item(KIND_QUERY, 47'd100000, '0);
    // One stale entry goes, then the next sits exactly on the lower edge.
    send_item(KIND_QUERY, 47'd400000, '0);
    send_item(KIND_QUERY, 47'd400000, '0);
    send_item(KIND_DROP, 47'd0, '0);
    send_item(KIND_PUSH, TIME_MAX[TIME_W-1:0], 32'h0000_0001);
    send_item(KIND_PUSH, 47'd5, 32'h0000_0002);
    send_item(KIND_PUSH, 47'd10, 32'h0000_0003);
    // Drop stops at the first entry that is later than the given time.
    send_item(KIND_DROP, 47'd5, '0);
    send_item(KIND_DROP, TIME_MAX[TIME_W-1:0], '0);
    send_item(KIND_PUSH, 47'd7, 32'h5A5A_5A5A);
    send_item(KIND_PUSH, 47'd8, 32'h1234_5678);
    send_item(KIND_CLEAR, TIME_MAX[TIME_W-1:0], 32'hFFFF_FFFF);
    send_item(KIND_PUSH, 47'd0, 32'h0000_00C3);
    send_item(KIND_QUERY, TIME_MAX[TIME_W-1:0], '0);
    send_item(KIND_PUSH, 47'd50, 32'h8000_0000);
    send_item(KIND_QUERY, 47'd0, '0);
    start <= 1'b0;
    drain();

    while (useful < 1700) begin
      sel = (phase_no < 6) ? phase_no : $urandom_range(0, 5);
      case (sel)
        0: off_v = 0;
        1: off_v = OFF_MIN;
        2: off_v = OFF_MAX;
        3: off_v = longint'($urandom_range(0, 2000000000)) - 1000000000;
        default: begin
          wide  = {$urandom, $urandom};
          off_v = longint'($signed(wide[OFF_W-1:0]));
        end
      endcase
      sel = (phase_no < 5) ? 4 - phase_no : $urandom_range(0, 4);
      case (sel)
        0: win_v = 0;
        1: win_v = WIN_MAX;
        2: win_v = 100000;
        default: win_v = longint'($urandom_range(1, 32'(WIN_MAX)));
      endcase
      sync_v = !(phase_no == 5 || $urandom_range(0, 7) == 0);
      fill   = (phase_no % 4 == 3);
      set_regs(sync_v, off_v, win_v);

      // Sensor times start where their local times land inside the target range.
      wide   = {$urandom, $urandom};
      sensor = longint'(wide[45:0]) - off_v;
      if (sensor < 0) begin
        sensor = longint'($urandom_range(0, 1000000));
      end
      if (sensor > TIME_MAX - (longint'(1) << 40)) begin
        sensor = TIME_MAX - (longint'(1) << 40);
      end
      step_max   = win_v + 1;
      no_gaps    = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 24);
      if (!sync_v) begin
        n_items = 20;
      end else if (fill) begin
        n_items = 200;
      end else begin
        n_items = $urandom_range(40, 120);
      end

      for (int i = 0; i < n_items; i++) begin
        r      = $urandom_range(0, 99);
        lag    = longint'($urandom_range(0, 3 * int'(step_max)));
        jitter = longint'($urandom_range(0, 2 * int'(win_v))) - win_v;
        if (r < (fill ? 88 : 45)) begin
          sensor = sensor + longint'($urandom_range(0, int'(step_max)));
          issue(KIND_PUSH, clamp_time(sensor), $urandom);
        end else if (r < (fill ? 94 : 80)) begin
          issue(KIND_QUERY, clamp_time(sensor - lag + off_v + jitter), $urandom);
        end else if (r < (fill ? 97 : 90)) begin
          issue(KIND_DROP, clamp_time(sensor - lag + off_v), $urandom);
        end else if (r < (fill ? 98 : 93)) begin
          issue(KIND_CLEAR, any_time(), $urandom);
        end else begin
          issue(kind_e'($urandom_range(0, 3)), any_time(), $urandom);
        end
      end
      start <= 1'b0;
      drain();
      if (sync_v) begin
        useful += n_items;
      end
      phase_no++;
    end

    // A stray result from a long scan would still arrive within this span.
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
